/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files.
// Expects signals named clk and rst in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define CHK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("websocket encoder check failed");

// Clocked check that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("websocket encoder reset check failed");

`endif

/* hdl/wsfe_pkg.sv */
// Shared types, constants and helpers for the WebSocket frame encoder.
// No dependencies.
package wsfe_pkg;

  localparam int LENGTH_BITS = 32;  // length bits kept from a start word
  localparam int REM_BITS    = 32;  // width of the payload byte counter
  localparam int CFG_IDX_BITS = 2;
  localparam int HIDX_BITS   = 4;   // header holds at most 14 bytes

  localparam logic [REM_BITS-1:0] LEN_MASK =
    (LENGTH_BITS >= REM_BITS) ? {REM_BITS{1'b1}}
                              : REM_BITS'((64'd1 << LENGTH_BITS) - 64'd1);

  // item_kind codes
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIN    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OPCODE = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MASK   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY    = 2'd3;

  // length field codes
  localparam logic [REM_BITS-1:0] LEN7_LIMIT  = REM_BITS'(126);
  localparam logic [REM_BITS-1:0] LEN16_MAX   = REM_BITS'(16'hffff);
  localparam logic [6:0]          LEN_CODE16  = 7'd126;
  localparam logic [6:0]          LEN_CODE64  = 7'd127;
  localparam logic [HIDX_BITS-1:0] LEN16_BYTES = 4'd2;
  localparam logic [HIDX_BITS-1:0] LEN64_BYTES = 4'd8;
  localparam logic [HIDX_BITS-1:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic        fin;
    logic [3:0]  opcode;
    logic        mask_en;
    logic [31:0] key;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hdr_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       frame_end;
    logic       run_last;
    logic       error_flag;
  } result_t;

  // key byte by position, position 0 is the first one on the wire
  function automatic logic [7:0] key_byte(input logic [31:0] key, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

/* hdl/wsfe_cfg.sv */
// Configuration registers of the frame encoder.
// Depends on wsfe_pkg.
module wsfe_cfg import wsfe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data,
  output cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fin     <= 1'b1;
      cfg.opcode  <= 4'd2;
      cfg.mask_en <= 1'b0;
      cfg.key     <= 32'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FIN:    cfg.fin     <= cfg_data[0];
        CFG_OPCODE: cfg.opcode  <= cfg_data[3:0];
        CFG_MASK:   cfg.mask_en <= cfg_data[0];
        CFG_KEY:    cfg.key     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hdl/wsfe_hdr.sv */
// Header byte lookup: byte at a given header position and whether it is the last.
// Depends on wsfe_pkg.
module wsfe_hdr import wsfe_pkg::*; (
  input  cfg_t                  cfg,
  input  logic [REM_BITS-1:0]   len,
  input  logic [HIDX_BITS-1:0]  idx,
  output hdr_t                  hdr
);

  logic                 len_short;
  logic                 len_mid;
  logic [HIDX_BITS-1:0] len_bytes;
  logic [HIDX_BITS-1:0] key_start;
  logic [HIDX_BITS-1:0] hdr_count;
  logic [HIDX_BITS-1:0] len_pos;
  logic [HIDX_BITS-1:0] key_pos;
  logic [63:0]          len64;
  logic [7:0]           len_be [8];
  logic [6:0]           len_code;

  assign len64 = {{(64-REM_BITS){1'b0}}, len};

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      len_be[i] = len64[8*(7-i) +: 8];  // big-endian order
    end
  end

  always_comb begin
    len_short = len < LEN7_LIMIT;
    len_mid   = !len_short && (len <= LEN16_MAX);
    len_bytes = len_short ? '0 : (len_mid ? LEN16_BYTES : LEN64_BYTES);
    len_code  = len_short ? len[6:0] : (len_mid ? LEN_CODE16 : LEN_CODE64);
    key_start = HIDX_BITS'(2) + len_bytes;
    hdr_count = key_start + (cfg.mask_en ? KEY_BYTES : '0);
    len_pos   = idx - HIDX_BITS'(2);
    key_pos   = idx - key_start;

    hdr.last = (idx == hdr_count - HIDX_BITS'(1));
    if (idx == '0) begin
      hdr.data = {cfg.fin, 3'b000, cfg.opcode};
    end else if (idx == HIDX_BITS'(1)) begin
      hdr.data = {cfg.mask_en, len_code};
    end else if (idx < key_start) begin
      if (len_mid) begin
        hdr.data = len_be[3'd6 + len_pos[2:0]];
      end else begin
        hdr.data = len_be[len_pos[2:0]];
      end
    end else begin
      hdr.data = key_byte(cfg.key, key_pos[1:0]);
    end
  end

endmodule

/* hdl/websocket_frame_encoder.sv */
// WebSocket frame encoder: turns start words and payload words into the byte
// stream of RFC 6455 frames. A payload word yields one byte and is taken every
// cycle while the result side keeps taking; a start word yields its header of
// 2 to 14 bytes, one per cycle, and holds the input until the last of them is
// loaded into the single result register, fed by a header byte counter.
// item_ready follows result_ready in the same cycle. No clearing pass after reset.
module websocket_frame_encoder import wsfe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  logic                    item_kind,
  input  logic [31:0]             frame_length,
  input  logic [7:0]              data_byte,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [7:0]              out_byte,
  output logic                    is_header,
  output logic                    frame_end,
  output logic                    run_last,
  output logic                    error_flag
);

  cfg_t cfg;
  hdr_t hdr;

  // word being worked on
  logic                 cur_valid;
  logic                 cur_kind;
  logic [REM_BITS-1:0]  cur_len;
  logic [7:0]           cur_data;
  logic [HIDX_BITS-1:0] hidx;
  logic [HIDX_BITS-1:0] hidx_next;

  // frame state
  logic [REM_BITS-1:0]  bytes_remaining;
  logic [REM_BITS-1:0]  bytes_remaining_next;
  logic [1:0]           key_index;
  logic [1:0]           key_index_next;

  logic    advance;
  logic    done;
  result_t res;
  result_t res_q;
  logic    out_valid;

  wsfe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wsfe_hdr u_hdr (
    .cfg (cfg),
    .len (cur_len),
    .idx (hidx),
    .hdr (hdr)
  );

  assign advance    = cur_valid && (!out_valid || result_ready);
  assign done       = advance && res.run_last;
  assign item_ready = !cur_valid || done;

  always_comb begin
    res                  = '0;
    hidx_next            = hidx;
    bytes_remaining_next = bytes_remaining;
    key_index_next       = key_index;
    if (cur_kind == KIND_START) begin
      res.out_byte  = hdr.data;
      res.is_header = 1'b1;
      res.run_last  = hdr.last;
      res.frame_end = hdr.last && (cur_len == '0);
      if (advance) begin
        if (hdr.last) begin
          hidx_next            = '0;
          bytes_remaining_next = cur_len;
          key_index_next       = '0;
        end else begin
          hidx_next = hidx + HIDX_BITS'(1);
        end
      end
    end else if (bytes_remaining == '0) begin
      // surplus payload byte: dropped, flagged
      res.run_last   = 1'b1;
      res.error_flag = 1'b1;
    end else begin
      res.out_byte  = cur_data ^ (cfg.mask_en ? key_byte(cfg.key, key_index) : 8'h00);
      res.run_last  = 1'b1;
      res.frame_end = (bytes_remaining == REM_BITS'(1));
      if (advance) begin
        bytes_remaining_next = bytes_remaining - REM_BITS'(1);
        key_index_next       = key_index + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid       <= 1'b0;
      hidx            <= '0;
      bytes_remaining <= '0;
      key_index       <= '0;
      out_valid       <= 1'b0;
    end else begin
      hidx            <= hidx_next;
      bytes_remaining <= bytes_remaining_next;
      key_index       <= key_index_next;
      if (item_valid && item_ready) begin
        cur_valid <= 1'b1;
      end else if (done) begin
        cur_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cur_kind <= item_kind;
      cur_len  <= frame_length[REM_BITS-1:0] & LEN_MASK;
      cur_data <= data_byte;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign result_valid = out_valid;
  assign out_byte     = res_q.out_byte;
  assign is_header    = res_q.is_header;
  assign frame_end    = res_q.frame_end;
  assign run_last     = res_q.run_last;
  assign error_flag   = res_q.error_flag;

endmodule

/* hdl/wsfe_checker.sv */
// Port-level checks for websocket_frame_encoder, bound to the top level.
// Depends on wsfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsfe_checker import wsfe_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_we,
  input logic [CFG_IDX_BITS-1:0] cfg_index,
  input logic [31:0]             cfg_data,
  input logic                    item_valid,
  input logic                    item_ready,
  input logic                    item_kind,
  input logic [31:0]             frame_length,
  input logic [7:0]              data_byte,
  input logic                    result_valid,
  input logic                    result_ready,
  input logic [7:0]              out_byte,
  input logic                    is_header,
  input logic                    frame_end,
  input logic                    run_last,
  input logic                    error_flag
);

  // a result word holds until taken
  `CHK_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(out_byte))

  // an error word carries nothing else
  `CHK_ASSERT(a_error_clean, result_valid && error_flag |-> out_byte == 8'h00 && !is_header && !frame_end && run_last)

  // payload words give a single result each
  `CHK_ASSERT(a_payload_single, result_valid && !is_header |-> run_last)

  // a header byte can only end the frame as the last byte of its start word
  `CHK_ASSERT(a_empty_frame_end, result_valid && is_header && frame_end |-> run_last && !error_flag)

  // nothing is offered right after reset
  `CHK_ASSERT_ALWAYS(a_reset_idle, rst |=> !result_valid)

endmodule

bind websocket_frame_encoder wsfe_checker u_wsfe_checker (.*);

/* verif/ws_frame_checker.sv */
// Checker for the WebSocket frame encoder: watches the config port and both
// channels, predicts the encoded byte stream and compares it word by word.
// Depends on wsfe_pkg for port widths, codes and the result layout.
`timescale 1ns / 1ps
module ws_frame_checker import wsfe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    item_valid,
  input  logic                    item_ready,
  input  logic                    item_kind,
  input  logic [31:0]             frame_length,
  input  logic [7:0]              data_byte,
  input  logic                    result_valid,
  input  logic                    result_ready,
  input  logic [7:0]              out_byte,
  input  logic                    is_header,
  input  logic                    frame_end,
  input  logic                    run_last,
  input  logic                    error_flag,
  output int                      outstanding,
  output int                      fail_count
);

  cfg_t                cfg;
  logic [REM_BITS-1:0] bytes_left;
  logic [1:0]          key_pos;
  result_t             wire_bytes_due[$];
  result_t             wire_bytes_seen[$];
  int                  mismatches = 0;

  function automatic logic [7:0] mask_byte_at(input logic [31:0] key, input logic [1:0] pos);
    return key[8 * (3 - int'(pos)) +: 8];
  endfunction

  function automatic void predict_header(input logic [31:0] raw_len);
    logic [63:0] len;
    logic [7:0]  hdr[$];
    result_t     r;
    len = {32'd0, raw_len & LEN_MASK};
    hdr.push_back({cfg.fin, 3'b000, cfg.opcode});
    if (len < LEN7_LIMIT) begin
      hdr.push_back({cfg.mask_en, len[6:0]});
    end else if (len <= LEN16_MAX) begin
      hdr.push_back({cfg.mask_en, LEN_CODE16});
      hdr.push_back(len[15:8]);
      hdr.push_back(len[7:0]);
    end else begin
      hdr.push_back({cfg.mask_en, LEN_CODE64});
      for (int i = 7; i >= 0; i--) hdr.push_back(len[8 * i +: 8]);
    end
    if (cfg.mask_en) begin
      for (int i = 0; i < 4; i++) hdr.push_back(mask_byte_at(cfg.key, 2'(i)));
    end
    foreach (hdr[i]) begin
      r.out_byte   = hdr[i];
      r.is_header  = 1'b1;
      r.run_last   = (i == hdr.size() - 1);
      r.frame_end  = r.run_last && (len == 0);
      r.error_flag = 1'b0;
      wire_bytes_due.push_back(r);
    end
    // a new start abandons whatever was left of the previous frame
    bytes_left = len[REM_BITS-1:0];
    key_pos    = '0;
  endfunction

  function automatic void predict_payload(input logic [7:0] b);
    result_t r;
    r = '0;
    r.run_last = 1'b1;
    if (bytes_left == 0) begin
      r.error_flag = 1'b1;  // surplus byte is dropped, state untouched
    end else begin
      r.out_byte  = cfg.mask_en ? (b ^ mask_byte_at(cfg.key, key_pos)) : b;
      key_pos     = key_pos + 2'd1;
      bytes_left  = bytes_left - 1'b1;
      r.frame_end = (bytes_left == 0);
    end
    wire_bytes_due.push_back(r);
  endfunction

  function automatic void compare_word(input result_t got, input result_t want);
    if (got.out_byte !== want.out_byte || got.is_header !== want.is_header ||
        got.frame_end !== want.frame_end || got.run_last !== want.run_last ||
        got.error_flag !== want.error_flag) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch: exp %02h hdr %0b end %0b last %0b err %0b",
                 $time, want.out_byte, want.is_header, want.frame_end, want.run_last,
                 want.error_flag);
      if (mismatches <= 10)
        $display("%0t:           got %02h hdr %0b end %0b last %0b err %0b",
                 $time, got.out_byte, got.is_header, got.frame_end,
                 got.run_last, got.error_flag);
    end
  endfunction

  // A start word can be accepted together with the last of its header bytes,
  // so results are queued and matched once the expectation exists.
  always @(posedge clk) begin
    if (rst) begin
      cfg        = '{fin: 1'b1, opcode: 4'd2, mask_en: 1'b0, key: 32'd0};
      bytes_left = '0;
      key_pos    = '0;
      wire_bytes_due.delete();
      wire_bytes_seen.delete();
    end else begin
      if (result_valid && result_ready)
        wire_bytes_seen.push_back(result_t'{out_byte, is_header, frame_end, run_last,
                                            error_flag});
      if (cfg_we) begin
        case (cfg_index)
          CFG_FIN:    cfg.fin     = cfg_data[0];
          CFG_OPCODE: cfg.opcode  = cfg_data[3:0];
          CFG_MASK:   cfg.mask_en = cfg_data[0];
          CFG_KEY:    cfg.key     = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        if (item_kind == KIND_START) predict_header(frame_length);
        else predict_payload(data_byte);
      end
      while (wire_bytes_seen.size() != 0 && wire_bytes_due.size() != 0)
        compare_word(wire_bytes_seen.pop_front(), wire_bytes_due.pop_front());
    end
    outstanding <= wire_bytes_due.size();
    // results left unmatched count as failures
    fail_count  <= mismatches + wire_bytes_seen.size();
  end

endmodule

/* verif/tb.sv */
// Top of the WebSocket frame encoder testbench: clock, reset, register writes,
// input words and result back-pressure. Depends on wsfe_pkg and ws_frame_checker.
`timescale 1ns / 1ps
module tb;
  import wsfe_pkg::*;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [31:0]             cfg_data;
  logic                    item_valid;
  logic                    item_ready;
  logic                    item_kind;
  logic [31:0]             frame_length;
  logic [7:0]              data_byte;
  logic                    result_valid;
  logic                    result_ready;
  logic [7:0]              out_byte;
  logic                    is_header;
  logic                    frame_end;
  logic                    run_last;
  logic                    error_flag;
  int                      outstanding;
  int                      fail_count;

  int words_sent = 0;
  int send_gap_pct;
  int recv_stall_pct;

  websocket_frame_encoder u_dut (.*);
  ws_frame_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) result_ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_word(input logic kind, input logic [31:0] len, input logic [7:0] b);
    if ($urandom_range(99) < send_gap_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    item_valid   <= 1'b1;
    item_kind    <= kind;
    frame_length <= len;
    data_byte    <= b;
    do @(posedge clk); while (!item_ready);
    words_sent++;
  endtask

  // the field that a kind ignores still gets random bits
  task automatic send_start(input logic [31:0] len);
    send_word(KIND_START, len, 8'($urandom()));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(KIND_PAYLOAD, $urandom(), b);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_config(input logic fin, input logic [3:0] opcode, input logic mask_en,
                              input logic [31:0] key);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIN;
    cfg_data  <= ($urandom() & 32'hffff_fffe) | 32'(fin);
    @(posedge clk);
    cfg_index <= CFG_OPCODE;
    cfg_data  <= ($urandom() & 32'hffff_fff0) | 32'(opcode);
    @(posedge clk);
    cfg_index <= CFG_MASK;
    cfg_data  <= ($urandom() & 32'hffff_fffe) | 32'(mask_en);
    @(posedge clk);
    cfg_index <= CFG_KEY;
    cfg_data  <= key;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random_frame();
    logic [31:0] len;
    int          sel;
    int          shape;
    int          nbytes;
    shape = $urandom_range(99);
    if (shape < 10) begin
      send_byte(8'($urandom()));  // stray word, may hit an open frame or error out
    end else begin
      sel = $urandom_range(99);
      if (sel < 75)      len = $urandom_range(0, 12);
      else if (sel < 80) len = $urandom_range(123, 129);
      else if (sel < 86) len = 32'd65535 + $urandom_range(0, 2) - 1;
      else if (sel < 90) len = $urandom_range(126, 70000);
      else               len = $urandom();
      nbytes = (len <= 130) ? int'(len) : $urandom_range(0, 4);
      if (shape < 25) nbytes = $urandom_range(0, nbytes);
      else if (shape < 40) nbytes = nbytes + $urandom_range(1, 3);
      send_start(len);
      repeat (nbytes) send_byte(8'($urandom()));
    end
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = CFG_FIN;
    cfg_data       = '0;
    item_valid     = 1'b0;
    item_kind      = KIND_START;
    frame_length   = '0;
    data_byte      = '0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: unmasked, empty frame, surplus bytes
    send_start(32'd0);
    send_byte(8'h5a);
    send_start(32'd3);
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'ha5);
    send_byte(8'h3c);
    wait_drained();

    // length form boundaries, abandoned frames, masking
    write_config(1'b0, 4'hf, 1'b1, 32'h1234_5678);
    send_start(32'd125);
    send_byte(8'h11);
    send_byte(8'hee);
    send_start(32'd126);
    send_start(32'd65535);
    send_start(32'd65536);
    send_start(32'hffff_ffff);
    send_start(32'd6);
    send_byte(8'hff);
    send_byte(8'h00);
    send_byte(8'h80);
    wait_drained();

    // key changed in the middle of a frame
    write_config(1'b1, 4'h9, 1'b1, 32'hffff_ffff);
    send_byte(8'h01);
    send_byte(8'hfe);
    send_byte(8'h7f);
    send_byte(8'h42);

    for (int ph = 0; ph < 4; ph++) begin
      int goal;
      wait_drained();
      case (ph)
        0: begin
          write_config(1'b1, 4'h0, 1'b1, 32'd0);
          send_gap_pct   <= 0;
          recv_stall_pct <= 0;
        end
        1: begin
          write_config(1'b0, 4'hf, 1'b0, $urandom());
          send_gap_pct   <= 54;
          recv_stall_pct <= 0;
        end
        2: begin
          write_config(1'($urandom()), 4'($urandom()), 1'b1, 32'hffff_ffff);
          send_gap_pct   <= 0;
          recv_stall_pct <= 54;
        end
        default: begin
          write_config(1'b1, 4'($urandom()), 1'b1, $urandom());
          send_gap_pct   <= 6;
          recv_stall_pct <= 6;
        end
      endcase
      goal = words_sent + 125;
      while (words_sent < goal) send_random_frame();
    end

    wait_drained();
    recv_stall_pct <= 0;
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
